[sv/assert_macros.svh]
// Assertion macros shared by the checker modules.
// No dependencies; included by files that hold concurrent assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication; the consequent may open with a fixed delay.
`define PBS_ASSERT_IMPLY(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> cons) \
      else $error("pbs assertion failed");

// Next-cycle implication.
`define PBS_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> cons) \
      else $error("pbs assertion failed");

`endif

[sv/pbs_pkg.sv]
// Shared types and constants for the poll backoff scheduler.
// No dependencies; used by the controller, datapath and top level.
package pbs_pkg;

   localparam int TIME_W  = 32;
   localparam int CNT_W   = 8;
   localparam int KIND_W  = 2;
   localparam int DEV_W   = 4;
   localparam int CAP_W   = 8;

   localparam logic [KIND_W-1:0] REQ_QUERY   = 2'd0;
   localparam logic [KIND_W-1:0] REQ_SUCCESS = 2'd1;
   localparam logic [KIND_W-1:0] REQ_FAILURE = 2'd2;
   localparam logic [KIND_W-1:0] REQ_CLEAR   = 2'd3;

   localparam logic [CAP_W-1:0] CAP_RESET   = 8'd8;
   localparam logic [CNT_W-1:0] CNT_MAX     = 8'd255;
   localparam logic [CNT_W-1:0] CNT_CAP_MIN = 8'd3;

   typedef struct packed {
      logic [TIME_W-1:0] success_time;
      logic [TIME_W-1:0] attempt_time;
      logic [CNT_W-1:0]  fail_count;
   } entry_type;

   typedef struct packed {
      logic load;    // capture request, read the entry
      logic calc;    // elapsed time and scaled interval
      logic finish;  // compare, write back, present result
   } ctl_cmd_type;

endpackage

[sv/pbs_ctrl.sv]
// Sequencer for the poll backoff scheduler: one request at a time.
// Depends on pbs_pkg for the command struct.
module pbs_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   output logic                 busy,
   output pbs_pkg::ctl_cmd_type cmd
);

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_CALC = 2'd1;
   localparam logic [1:0] ST_FIN  = 2'd2;

   logic [1:0] state_ff;
   logic [1:0] state_in;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) state_in = ST_CALC;
         end
         ST_CALC: state_in = ST_FIN;
         ST_FIN:  state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign busy       = (state_ff != ST_IDLE);
   assign cmd.load   = (state_ff == ST_IDLE) && start;
   assign cmd.calc   = (state_ff == ST_CALC);
   assign cmd.finish = (state_ff == ST_FIN);

endmodule

[sv/pbs_datapath.sv]
// Datapath for the poll backoff scheduler: device table memory, valid bits,
// backoff arithmetic and result registers. Depends on pbs_pkg.
module pbs_datapath #(
   parameter int DEVICES = 16
) (
   input  logic                               clock,
   input  logic                               reset,
   input  pbs_pkg::ctl_cmd_type               cmd,
   input  logic [pbs_pkg::KIND_W-1:0]         req_type,
   input  logic [pbs_pkg::DEV_W-1:0]          req_dev_index,
   input  logic [pbs_pkg::TIME_W-1:0]         req_poll_interval,
   input  logic [pbs_pkg::TIME_W-1:0]         req_now_time,
   input  logic                               cap_we,
   input  logic [pbs_pkg::CAP_W-1:0]          cap_wdata,
   output logic                               rsp_valid,
   output logic                               rsp_due_now,
   output logic [pbs_pkg::CNT_W-1:0]          rsp_fail_total,
   output logic [pbs_pkg::TIME_W-1:0]         rsp_last_success_time
);

   localparam int IDX_W = (DEVICES > 1) ? $clog2(DEVICES) : 1;

   // table storage, no reset; valid bits stand in for the cleared state
   pbs_pkg::entry_type mem [DEVICES];
   logic [DEVICES-1:0] valid_ff;

   logic [pbs_pkg::CAP_W-1:0]  cap_ff;

   logic [pbs_pkg::KIND_W-1:0] kind_ff;
   logic [IDX_W-1:0]           idx_ff;
   logic                       in_range_ff;
   logic [pbs_pkg::TIME_W-1:0] interval_ff;
   logic [pbs_pkg::TIME_W-1:0] now_ff;
   pbs_pkg::entry_type         rd_entry_ff;
   logic                       rd_valid_ff;

   logic [pbs_pkg::TIME_W-1:0] elapsed_ff;
   logic [pbs_pkg::TIME_W-1:0] limit_ff;
   logic                       never_ff;

   logic                       rsp_valid_ff;
   logic                       rsp_due_ff;
   logic [pbs_pkg::CNT_W-1:0]  rsp_fail_ff;
   logic [pbs_pkg::TIME_W-1:0] rsp_succ_ff;

   logic [IDX_W-1:0]           rd_addr;
   logic                       in_range;
   pbs_pkg::entry_type         entry_cur;
   logic [pbs_pkg::CAP_W-1:0]  scale;
   logic [pbs_pkg::TIME_W-1:0] product;
   pbs_pkg::entry_type         entry_new;
   logic                       entry_we;
   logic                       due;

   assign rd_addr  = IDX_W'(req_dev_index);
   assign in_range = (32'(req_dev_index) < DEVICES);

   assign entry_cur = rd_valid_ff ? rd_entry_ff : '0;

   always_comb begin
      if (entry_cur.fail_count >= pbs_pkg::CNT_CAP_MIN) begin
         scale = cap_ff;
      end else begin
         scale = pbs_pkg::CAP_W'(1) << entry_cur.fail_count[1:0];
      end
   end

   // scaled interval wraps at 32 bits
   assign product = interval_ff * pbs_pkg::TIME_W'(scale);

   always_comb begin
      entry_new = entry_cur;
      entry_we  = 1'b0;
      unique case (kind_ff)
         pbs_pkg::REQ_SUCCESS: begin
            entry_new.success_time = now_ff;
            entry_new.attempt_time = now_ff;
            entry_new.fail_count   = '0;
            entry_we               = in_range_ff;
         end
         pbs_pkg::REQ_FAILURE: begin
            entry_new.attempt_time = now_ff;
            if (entry_cur.fail_count != pbs_pkg::CNT_MAX) begin
               entry_new.fail_count = entry_cur.fail_count + pbs_pkg::CNT_W'(1);
            end
            entry_we = in_range_ff;
         end
         pbs_pkg::REQ_QUERY,
         pbs_pkg::REQ_CLEAR: begin
            entry_we = 1'b0;
         end
         default: entry_we = 1'b0;
      endcase
   end

   assign due = (kind_ff == pbs_pkg::REQ_QUERY) && in_range_ff &&
                (never_ff || (elapsed_ff >= limit_ff));

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         rd_entry_ff <= mem[rd_addr];
      end
      if (cmd.finish && entry_we) begin
         mem[idx_ff] <= entry_new;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
         cap_ff   <= pbs_pkg::CAP_RESET;
      end else begin
         if (cap_we) begin
            cap_ff <= cap_wdata;
         end
         if (cmd.finish) begin
            if (kind_ff == pbs_pkg::REQ_CLEAR) begin
               valid_ff <= '0;
            end else if (entry_we) begin
               valid_ff[idx_ff] <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         kind_ff     <= req_type;
         idx_ff      <= rd_addr;
         in_range_ff <= in_range;
         interval_ff <= req_poll_interval;
         now_ff      <= req_now_time;
         rd_valid_ff <= in_range ? valid_ff[rd_addr] : 1'b0;
      end
      if (cmd.calc) begin
         elapsed_ff <= now_ff - entry_cur.attempt_time;
         limit_ff   <= product;
         never_ff   <= (entry_cur.attempt_time == '0);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= cmd.finish;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.finish) begin
         rsp_due_ff <= due;
         if (in_range_ff && (kind_ff != pbs_pkg::REQ_CLEAR)) begin
            rsp_fail_ff <= entry_new.fail_count;
            rsp_succ_ff <= entry_new.success_time;
         end else begin
            rsp_fail_ff <= '0;
            rsp_succ_ff <= '0;
         end
      end
   end

   assign rsp_valid             = rsp_valid_ff;
   assign rsp_due_now           = rsp_due_ff;
   assign rsp_fail_total        = rsp_fail_ff;
   assign rsp_last_success_time = rsp_succ_ff;

endmodule

[sv/poll_backoff_scheduler.sv]
// Poll backoff scheduler, top level: controller plus datapath.
// Depends on pbs_pkg, pbs_ctrl and pbs_datapath.
//
// Usage:
//   Request channel: drive req_* and raise start; the request is taken at a
//   rising edge with start high and busy low. busy stays high until the
//   result is produced.
//   Result channel: rsp_valid pulses for one cycle with rsp_due_now,
//   rsp_fail_total and rsp_last_success_time. The receiver cannot stall;
//   it must take the result in that cycle.
//   CSR channel: csr_wdata loads backoff_cap when csr_valid and csr_ready
//   are high; csr_ready is always high. Write only while idle.
//   Sequence: the request is loaded at the accepting edge, then passes
//   the CALC and FIN states; the result is registered at the end of FIN.
//   Only one request is in flight; the next waits for the table read, the
//   registered interval-times-scale multiply, then compare and write-back.
//   A new request may be taken in the same cycle a result is shown.
//   Reset: synchronous; table reads as all zero (valid bits cleared),
//   backoff_cap returns to 8, no result is pending.
module poll_backoff_scheduler #(
   parameter int DEVICES = 16
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   output logic                         busy,
   input  logic [pbs_pkg::KIND_W-1:0]   req_type,
   input  logic [pbs_pkg::DEV_W-1:0]    req_dev_index,
   input  logic [pbs_pkg::TIME_W-1:0]   req_poll_interval,
   input  logic [pbs_pkg::TIME_W-1:0]   req_now_time,
   output logic                         rsp_valid,
   output logic                         rsp_due_now,
   output logic [pbs_pkg::CNT_W-1:0]    rsp_fail_total,
   output logic [pbs_pkg::TIME_W-1:0]   rsp_last_success_time,
   input  logic                         csr_valid,
   output logic                         csr_ready,
   input  logic [pbs_pkg::CAP_W-1:0]    csr_wdata
);

   pbs_pkg::ctl_cmd_type cmd;

   assign csr_ready = 1'b1;

   pbs_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .busy  (busy),
      .cmd   (cmd)
   );

   pbs_datapath #(
      .DEVICES (DEVICES)
   ) u_datapath (
      .clock                 (clock),
      .reset                 (reset),
      .cmd                   (cmd),
      .req_type              (req_type),
      .req_dev_index         (req_dev_index),
      .req_poll_interval     (req_poll_interval),
      .req_now_time          (req_now_time),
      .cap_we                (csr_valid && csr_ready),
      .cap_wdata             (csr_wdata),
      .rsp_valid             (rsp_valid),
      .rsp_due_now           (rsp_due_now),
      .rsp_fail_total        (rsp_fail_total),
      .rsp_last_success_time (rsp_last_success_time)
   );

endmodule

[sv/pbs_checker.sv]
// Port-level checks for the poll backoff scheduler, bound to the top level.
// Depends on pbs_pkg and assert_macros.svh.
`include "assert_macros.svh"

module pbs_checker (
   input logic                         clock,
   input logic                         reset,
   input logic                         start,
   input logic                         busy,
   input logic [pbs_pkg::KIND_W-1:0]   req_type,
   input logic                         rsp_valid,
   input logic                         rsp_due_now,
   input logic [pbs_pkg::CNT_W-1:0]    rsp_fail_total,
   input logic [pbs_pkg::TIME_W-1:0]   rsp_last_success_time
);

   logic accept;
   logic accept_other;
   logic accept_clear;
   logic rsp_zero;

   assign accept       = start && !busy;
   assign accept_other = accept && (req_type != pbs_pkg::REQ_QUERY);
   assign accept_clear = accept && (req_type == pbs_pkg::REQ_CLEAR);
   assign rsp_zero     = (rsp_fail_total == '0) && (rsp_last_success_time == '0);

   // each accepted transaction yields its result after the CALC and FIN states
   `PBS_ASSERT_IMPLY(a_rsp_latency, clock, reset, accept, ##3 rsp_valid)

   // result only shows once the sequencer is back to idle
   `PBS_ASSERT_IMPLY(a_rsp_idle, clock, reset, rsp_valid, !busy)

   `PBS_ASSERT_NEXT(a_rsp_pulse, clock, reset, rsp_valid, !rsp_valid)

   // only a query can report a due poll
   `PBS_ASSERT_IMPLY(a_due_query, clock, reset, accept_other, ##3 !rsp_due_now)

   `PBS_ASSERT_IMPLY(a_clear_zero, clock, reset, accept_clear, ##3 rsp_zero)

endmodule

bind poll_backoff_scheduler pbs_checker u_pbs_checker (
   .clock                 (clock),
   .reset                 (reset),
   .start                 (start),
   .busy                  (busy),
   .req_type              (req_type),
   .rsp_valid             (rsp_valid),
   .rsp_due_now           (rsp_due_now),
   .rsp_fail_total        (rsp_fail_total),
   .rsp_last_success_time (rsp_last_success_time)
);
